FILE: sv/ptzcfe_pkg.sv
// Package for the PTZ command frame encoder: frame constants, the command
// word ROM and the queue entry type. Used by every module of the block.
package ptzcfe_pkg;

   localparam int unsigned AddrWidth    = 8;
   localparam int unsigned IdWidth      = 5;
   localparam int unsigned SpeedWidth   = 16;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 8;
   localparam int unsigned IdxWidth     = 3;
   localparam int unsigned QueueDepth   = 2;

   // Protocol selector codes
   localparam logic ProtoD = 1'b0;
   localparam logic ProtoP = 1'b1;

   // Frame constants
   localparam logic [ByteWidth-1:0] SyncD = 8'hFF;
   localparam logic [ByteWidth-1:0] StxP  = 8'hA0;
   localparam logic [ByteWidth-1:0] EtxP  = 8'hAF;

   // Byte positions within a frame
   localparam logic [IdxWidth-1:0] PosSync    = 3'd0;
   localparam logic [IdxWidth-1:0] PosAddr    = 3'd1;
   localparam logic [IdxWidth-1:0] PosCmdHi   = 3'd2;
   localparam logic [IdxWidth-1:0] PosCmdLo   = 3'd3;
   localparam logic [IdxWidth-1:0] PosSpdHi   = 3'd4;
   localparam logic [IdxWidth-1:0] PosSpdLo   = 3'd5;
   localparam logic [IdxWidth-1:0] PosSixth   = 3'd6;
   localparam logic [IdxWidth-1:0] PosChkP    = 3'd7;

   // One bit per control id that counts as found (bit 19 also, with a zero word)
   localparam logic [31:0] RomValidD = 32'hFB0F_C3FF;
   localparam logic [31:0] RomValidP = 32'hFB08_C3FF;

   typedef struct packed {
      logic                    proto;
      logic                    found;
      logic [ByteWidth-1:0]    addr_byte;
      logic [15:0]             cmd;
      logic [SpeedWidth-1:0]   speed;
      logic [ByteWidth-1:0]    chk;
   } entry_type;

   function automatic logic rom_found(input logic proto, input logic [IdWidth-1:0] id);
      logic hit;
      hit = (proto == ProtoP) ? RomValidP[id] : RomValidD[id];
      return hit;
   endfunction

   function automatic logic [15:0] rom_cmd(input logic proto, input logic [IdWidth-1:0] id);
      logic [15:0] word;
      word = 16'h0000;
      case ({proto, id})
         {ProtoD, 5'd0},  {ProtoP, 5'd0}:  word = 16'h0008;
         {ProtoD, 5'd1},  {ProtoP, 5'd1}:  word = 16'h0010;
         {ProtoD, 5'd2},  {ProtoP, 5'd2}:  word = 16'h0004;
         {ProtoD, 5'd3},  {ProtoP, 5'd3}:  word = 16'h0002;
         {ProtoD, 5'd4}:                   word = 16'h0400;
         {ProtoD, 5'd5}:                   word = 16'h0200;
         {ProtoD, 5'd6},  {ProtoP, 5'd6}:  word = 16'h0100;
         {ProtoD, 5'd7}:                   word = 16'h0080;
         {ProtoD, 5'd8},  {ProtoP, 5'd8}:  word = 16'h0040;
         {ProtoD, 5'd9},  {ProtoP, 5'd9}:  word = 16'h0020;
         {ProtoD, 5'd14}:                  word = 16'h9000;
         {ProtoD, 5'd15}:                  word = 16'h0090;
         {ProtoD, 5'd16}:                  word = 16'h0007;
         {ProtoD, 5'd17}:                  word = 16'h001B;
         {ProtoD, 5'd18}:                  word = 16'h001D;
         {ProtoD, 5'd24}, {ProtoP, 5'd24}: word = 16'h0003;
         {ProtoD, 5'd25}, {ProtoP, 5'd25}: word = 16'h0007;
         {ProtoD, 5'd27}, {ProtoP, 5'd27}: word = 16'h001F;
         {ProtoD, 5'd28}, {ProtoP, 5'd28}: word = 16'h0021;
         {ProtoD, 5'd29}, {ProtoP, 5'd29}: word = 16'h0023;
         {ProtoD, 5'd30}, {ProtoP, 5'd30}: word = 16'h0009;
         {ProtoD, 5'd31}, {ProtoP, 5'd31}: word = 16'h000B;
         {ProtoP, 5'd4}:                   word = 16'h0800;
         {ProtoP, 5'd5}:                   word = 16'h0400;
         {ProtoP, 5'd7}:                   word = 16'h0200;
         {ProtoP, 5'd14}:                  word = 16'h0019;
         {ProtoP, 5'd15}:                  word = 16'h0200;
         default:                          word = 16'h0000;
      endcase
      return word;
   endfunction

endpackage

FILE: sv/ptzcfe_front.sv
// Front end: accepts a request beat, looks up the command word and
// precomputes the address byte and checksum. Depends on ptzcfe_pkg.
module ptzcfe_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               proto,
   input  logic [ptzcfe_pkg::AddrWidth-1:0]   address,
   input  logic [ptzcfe_pkg::IdWidth-1:0]     control_id,
   input  logic [ptzcfe_pkg::SpeedWidth-1:0]  speed,
   input  logic                               queue_full,
   output logic                               push,
   output ptzcfe_pkg::entry_type              entry
);

   logic [ptzcfe_pkg::ByteWidth-1:0] addr_byte;
   logic [15:0]                      cmd;
   logic [ptzcfe_pkg::ByteWidth-1:0] sum_d;
   logic [ptzcfe_pkg::ByteWidth-1:0] xor_p;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      cmd       = ptzcfe_pkg::rom_cmd(proto, control_id);
      // P frames carry the address minus one, wrapping
      addr_byte = (proto == ptzcfe_pkg::ProtoP) ? address - 8'd1 : address;
      sum_d     = address + cmd[15:8] + cmd[7:0] + speed[15:8] + speed[7:0];
      xor_p     = addr_byte ^ cmd[15:8] ^ cmd[7:0] ^ speed[15:8] ^ speed[7:0]
                  ^ ptzcfe_pkg::EtxP;

      entry.proto     = proto;
      entry.found     = ptzcfe_pkg::rom_found(proto, control_id);
      entry.addr_byte = addr_byte;
      entry.cmd       = cmd;
      entry.speed     = speed;
      entry.chk       = (proto == ptzcfe_pkg::ProtoP) ? xor_p : sum_d;
   end

endmodule

FILE: sv/ptzcfe_queue.sv
// Short queue of classified commands between front and back end.
// Depends on ptzcfe_pkg for the entry type.
module ptzcfe_queue #(
   parameter int unsigned Depth = ptzcfe_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ptzcfe_pkg::entry_type push_entry,
   input  logic                  pop,
   output ptzcfe_pkg::entry_type head,
   output logic                  empty,
   output logic                  full
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   ptzcfe_pkg::entry_type  mem [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CntWidth'(Depth));
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(Depth))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

FILE: sv/ptzcfe_back.sv
// Back end: walks the head entry byte by byte into a registered output
// stage and pops the entry on its final byte. Depends on ptzcfe_pkg.
module ptzcfe_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ptzcfe_pkg::entry_type               head,
   input  logic                                empty,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptzcfe_pkg::ByteWidth-1:0]    frame_byte,
   output logic                                last,
   output logic                                not_found
);

   logic [ptzcfe_pkg::IdxWidth-1:0]  idx_ff, idx_in;
   logic                             valid_ff, valid_in;
   logic [ptzcfe_pkg::ByteWidth-1:0] byte_ff, byte_in;
   logic                             last_ff, last_in;
   logic                             nf_ff, nf_in;
   logic                             load;
   logic [ptzcfe_pkg::ByteWidth-1:0] cur_byte;
   logic                             cur_last;
   logic [ptzcfe_pkg::IdxWidth-1:0]  final_pos;

   assign load = !empty && (!valid_ff || rsp_tready);
   assign pop  = load && cur_last;

   always_comb begin
      final_pos = (head.proto == ptzcfe_pkg::ProtoP) ? ptzcfe_pkg::PosChkP
                                                     : ptzcfe_pkg::PosSixth;
      case (idx_ff)
         ptzcfe_pkg::PosSync:
            cur_byte = (head.proto == ptzcfe_pkg::ProtoP) ? ptzcfe_pkg::StxP
                                                          : ptzcfe_pkg::SyncD;
         ptzcfe_pkg::PosAddr:  cur_byte = head.addr_byte;
         ptzcfe_pkg::PosCmdHi: cur_byte = head.cmd[15:8];
         ptzcfe_pkg::PosCmdLo: cur_byte = head.cmd[7:0];
         ptzcfe_pkg::PosSpdHi: cur_byte = head.speed[15:8];
         ptzcfe_pkg::PosSpdLo: cur_byte = head.speed[7:0];
         ptzcfe_pkg::PosSixth:
            cur_byte = (head.proto == ptzcfe_pkg::ProtoP) ? ptzcfe_pkg::EtxP
                                                          : head.chk;
         default:              cur_byte = head.chk;
      endcase
      // a missing entry gives one zero byte flagged not found
      if (!head.found) begin
         cur_byte = '0;
      end
      cur_last = !head.found || (idx_ff == final_pos);

      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      nf_in    = nf_ff;
      if (load) begin
         idx_in   = cur_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = cur_last;
         nf_in    = !head.found;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      nf_ff   <= nf_in;
   end

   assign rsp_tvalid = valid_ff;
   assign frame_byte = byte_ff;
   assign last       = last_ff;
   assign not_found  = nf_ff;

   a_idx_needs_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> !empty)
      else $error("mid-frame with no queued command");

   a_idx_in_frame: assert property (@(posedge clock) disable iff (reset)
      (!empty && head.proto == ptzcfe_pkg::ProtoD) |-> (idx_ff != ptzcfe_pkg::PosChkP))
      else $error("D frame walked past its checksum");

   a_nf_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && nf_ff) |-> last_ff)
      else $error("not-found beat without last");

endmodule

FILE: sv/ptz_command_frame_encoder.sv
// Top level of the PTZ command frame encoder: front end, command queue and
// byte serializer. Depends on ptzcfe_pkg, ptzcfe_front, ptzcfe_queue, ptzcfe_back.
//
// Usage:
//   req_* carries one camera command per beat: req_tuser selects the frame
//   format (0 = D, 1 = P), req_tdata packs address, control id and speed.
//   rsp_* returns the frame one byte per beat: 7 beats for D, 8 for P, with
//   rsp_tlast on the checksum byte. A protocol/control id pair with no table
//   entry returns a single zero byte with rsp_tlast and rsp_tuser high.
// Path: when the serializer is free, the first byte of a frame passes
//   through the queue entry and then the output byte register to rsp_*.
// Throughput: one byte per cycle from the serializer while rsp_tready stays
//   high; each request holds it for every byte of its frame (a single byte
//   for a missing entry).
// The command queue (QueueDepth entries) takes requests while the current
//   frame still streams; req_tready drops only when it is full.
// Stall: with rsp_tready low the output byte holds and the serializer waits;
//   the queue keeps filling until full.
// Reset: synchronous, active high; clears the queue, the output valid flag and the byte index.
module ptz_command_frame_encoder #(
   parameter int unsigned QueueDepth = ptzcfe_pkg::QueueDepth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] address, [12:8] control_id, [28:13] speed, [31:29] zero
   input  logic [ptzcfe_pkg::ReqDataWidth-1:0]   req_tdata,
   // [0] protocol
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] frame_byte
   output logic [ptzcfe_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic                                  rsp_tlast,
   // [0] not_found
   output logic                                  rsp_tuser
);

   logic                  push;
   logic                  pop;
   logic                  empty;
   logic                  full;
   ptzcfe_pkg::entry_type push_entry;
   ptzcfe_pkg::entry_type head;

   // Classify the request beat and push it straight into the queue
   ptzcfe_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .proto      (req_tuser),
      .address    (req_tdata[7:0]),
      .control_id (req_tdata[12:8]),
      .speed      (req_tdata[28:13]),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   // Decouple request acceptance from frame serialization
   ptzcfe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   // Serialize the head command one byte per beat
   ptzcfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .frame_byte (rsp_tdata),
      .last       (rsp_tlast),
      .not_found  (rsp_tuser)
   );

endmodule
